// File: rtl/core/signed_decimal_lcd_segment_encoder_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signed decimal LCD segment encoder
// Same-cycle and next-cycle implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_DECIMAL_LCD_SEGMENT_ENCODER_TOP_ASSERT_SVH
`define SIGNED_DECIMAL_LCD_SEGMENT_ENCODER_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define SDLCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdlcd same-cycle check failed");

// Check that cons holds in the cycle after ante
`define SDLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdlcd next-cycle check failed");

`endif

// File: rtl/core/sdlcd_pkg.sv
// ----------------------------------------------------------------------------
// sdlcd_pkg
// Shared widths, item types, segment constants and digit table.
// ----------------------------------------------------------------------------
package sdlcd_pkg;

    // Field widths
    localparam int unsigned KIND_W = 3;
    localparam int unsigned NUM_W  = 20;
    localparam int unsigned WORD_W = 12;
    localparam int unsigned LINES  = 4;
    localparam int unsigned DIGITS = 5;
    localparam int unsigned SEG_W  = 2 * DIGITS;

    // Magnitude and quotient widths (valid range below the error limit)
    localparam int unsigned MAG_W  = 17;
    localparam int unsigned Q1_W   = 14;
    localparam int unsigned Q2_W   = 10;
    localparam int unsigned Q3_W   = 7;
    localparam int unsigned Q4_W   = 4;
    localparam int unsigned RCP_W  = 18;
    localparam int unsigned PROD_W = MAG_W + RCP_W;

    // Display kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_NUMBER = 3'd0,
        KIND_CONFIG = 3'd1,
        KIND_DASHES = 3'd2,
        KIND_BLANK  = 3'd3,
        KIND_ALL_ON = 3'd4
    } t_kind;

    // Error threshold on the magnitude
    localparam logic [NUM_W-1:0] OVER_LIMIT = 20'd100000;

    // Reciprocals: q = (mag * RCP) >> SHIFT, exact for mag < 2**17
    localparam logic [RCP_W-1:0] RCP_1E4 = 18'd214749;
    localparam logic [RCP_W-1:0] RCP_1E3 = 18'd134218;
    localparam logic [RCP_W-1:0] RCP_1E2 = 18'd167773;
    localparam logic [RCP_W-1:0] RCP_1E1 = 18'd209716;
    localparam int unsigned SH_1E4 = 31;
    localparam int unsigned SH_1E3 = 27;
    localparam int unsigned SH_1E2 = 24;
    localparam int unsigned SH_1E1 = 21;

    // Segment marks
    localparam logic [WORD_W-1:0] UNIT_MARK  = 12'h400;
    localparam logic [WORD_W-1:0] DOT_MARK   = 12'h008;
    localparam logic [WORD_W-1:0] MINUS_MARK = 12'h002;
    localparam logic [WORD_W-1:0] FLAG_MARK  = 12'h800;
    localparam logic [WORD_W-1:0] DASH_ROW   = 12'h155;
    localparam logic [WORD_W-1:0] ALL_ON     = 12'hFFF;

    // Error pattern, ORed over the number-mode base words
    localparam logic [WORD_W-1:0] ERR_LINE0 = 12'h403;
    localparam logic [WORD_W-1:0] ERR_LINE1 = 12'h155;
    localparam logic [WORD_W-1:0] ERR_LINE2 = 12'h1D5;
    localparam logic [WORD_W-1:0] ERR_LINE3 = 12'h041;

    // Config pattern
    localparam logic [WORD_W-1:0] CFG_LINE0 = 12'h43F;
    localparam logic [WORD_W-1:0] CFG_LINE1 = 12'h004;
    localparam logic [WORD_W-1:0] CFG_LINE2 = 12'h035;
    localparam logic [WORD_W-1:0] CFG_LINE3 = 12'h011;

    // Table entry that draws only the middle bar
    localparam logic [3:0] DIGIT_BAR = 4'd10;

    // Two bits per common line, indexed by line
    typedef logic [LINES-1:0][1:0] t_pat;

    // Raw input item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NUM_W-1:0]  number;
        logic              extra_mark;
        logic [WORD_W-1:0] indicator_bits;
    } t_item;

    // Item after sign removal and decimal split
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              neg;
        logic              mark;
        logic              ovf;
        logic [WORD_W-1:0] ind;
        logic [MAG_W-1:0]  mag;
        logic [Q1_W-1:0]   q1;
        logic [Q2_W-1:0]   q2;
        logic [Q3_W-1:0]   q3;
        logic [Q4_W-1:0]   q4;
    } t_split;

    // Digit table, entries listed line3 .. line0
    function automatic t_pat digit_pat(input logic [3:0] d);
        t_pat p;
        case (d)
            4'd0:      p = {2'h1, 2'h3, 2'h2, 2'h3};
            4'd1:      p = {2'h0, 2'h2, 2'h2, 2'h0};
            4'd2:      p = {2'h1, 2'h1, 2'h3, 2'h2};
            4'd3:      p = {2'h1, 2'h2, 2'h3, 2'h2};
            4'd4:      p = {2'h0, 2'h2, 2'h3, 2'h1};
            4'd5:      p = {2'h1, 2'h2, 2'h1, 2'h3};
            4'd6:      p = {2'h1, 2'h3, 2'h1, 2'h3};
            4'd7:      p = {2'h0, 2'h2, 2'h2, 2'h2};
            4'd8:      p = {2'h1, 2'h3, 2'h3, 2'h3};
            4'd9:      p = {2'h1, 2'h2, 2'h3, 2'h3};
            DIGIT_BAR: p = {2'h0, 2'h0, 2'h1, 2'h0};
            default:   p = '0;
        endcase
        return p;
    endfunction

endpackage

// File: rtl/core/sdlcd_item_if.sv
// ----------------------------------------------------------------------------
// sdlcd_item_if
// Input channel: valid/ready handshake with the display request fields.
// ----------------------------------------------------------------------------
interface sdlcd_item_if
    import sdlcd_pkg::*;
();

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [NUM_W-1:0]  number;
    logic                     extra_mark;
    logic [WORD_W-1:0]        indicator_bits;

    modport source (
        output valid, kind, number, extra_mark, indicator_bits,
        input  ready
    );

    modport sink (
        input  valid, kind, number, extra_mark, indicator_bits,
        output ready
    );

endinterface

// File: rtl/core/sdlcd_result_if.sv
// ----------------------------------------------------------------------------
// sdlcd_result_if
// Output channel: valid/ready handshake with four segment words and a flag.
// ----------------------------------------------------------------------------
interface sdlcd_result_if
    import sdlcd_pkg::*;
();

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] line0_word;
    logic [WORD_W-1:0] line1_word;
    logic [WORD_W-1:0] line2_word;
    logic [WORD_W-1:0] line3_word;
    logic              overflow;

    modport source (
        output valid, line0_word, line1_word, line2_word, line3_word, overflow,
        input  ready
    );

    modport sink (
        input  valid, line0_word, line1_word, line2_word, line3_word, overflow,
        output ready
    );

endinterface

// File: rtl/core/sdlcd_capture.sv
// ----------------------------------------------------------------------------
// sdlcd_capture
// Input register stage: latch each accepted item.
// ----------------------------------------------------------------------------
module sdlcd_capture
    import sdlcd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    sdlcd_item_if.sink        i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output t_item             o_data
);

    logic  r_valid;
    t_item r_data;
    logic  n_valid;
    logic  take;

    // Take a new item when empty or when the next stage drains this one
    assign i_item.ready = !r_valid || i_ready;
    assign take         = i_item.valid && i_item.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_item.ready) begin
            n_valid = i_item.valid;
        end
    end

    // Clear valid under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Latch payload on accept
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data.kind           <= i_item.kind;
            r_data.number         <= i_item.number;
            r_data.extra_mark     <= i_item.extra_mark;
            r_data.indicator_bits <= i_item.indicator_bits;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/core/sdlcd_split.sv
// ----------------------------------------------------------------------------
// sdlcd_split
// Magnitude stage: strip the sign, flag overflow, and form the decimal
// quotients by 10, 100, 1000 and 10000 through reciprocal multiplies.
// ----------------------------------------------------------------------------
module sdlcd_split
    import sdlcd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_item  i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_split o_data
);

    logic               r_valid;
    t_split             r_data;
    logic               n_valid;
    t_split             n_data;
    logic [NUM_W-1:0]   raw;
    logic [NUM_W-1:0]   mag_full;
    logic [MAG_W-1:0]   mag;
    logic [PROD_W-1:0]  prod4;
    logic [PROD_W-1:0]  prod3;
    logic [PROD_W-1:0]  prod2;
    logic [PROD_W-1:0]  prod1;

    assign o_ready = !r_valid || i_ready;

    // Two's complement magnitude; the most negative value stays 0x80000
    assign raw      = i_data.number;
    assign mag_full = raw[NUM_W-1] ? (~raw + NUM_W'(1)) : raw;
    assign mag      = mag_full[MAG_W-1:0];

    // Quotients by powers of ten, exact below the error limit
    assign prod4 = PROD_W'(mag) * PROD_W'(RCP_1E4);
    assign prod3 = PROD_W'(mag) * PROD_W'(RCP_1E3);
    assign prod2 = PROD_W'(mag) * PROD_W'(RCP_1E2);
    assign prod1 = PROD_W'(mag) * PROD_W'(RCP_1E1);

    always_comb begin
        n_data.kind = i_data.kind;
        n_data.neg  = raw[NUM_W-1];
        n_data.mark = i_data.extra_mark;
        n_data.ovf  = (mag_full >= OVER_LIMIT);
        n_data.ind  = i_data.indicator_bits;
        n_data.mag  = mag;
        n_data.q4   = prod4[SH_1E4 +: Q4_W];
        n_data.q3   = prod3[SH_1E3 +: Q3_W];
        n_data.q2   = prod2[SH_1E2 +: Q2_W];
        n_data.q1   = prod1[SH_1E1 +: Q1_W];
    end

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Advance payload when this stage takes an item
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/core/sdlcd_encode.sv
// ----------------------------------------------------------------------------
// sdlcd_encode
// Result stage: extract the five digits, map them through the segment table
// and assemble the four common-line words for the selected display kind.
// ----------------------------------------------------------------------------
module sdlcd_encode
    import sdlcd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  t_split        i_data,
    sdlcd_result_if.source o_result
);

    logic                          r_valid;
    logic [LINES-1:0][WORD_W-1:0]  r_word;
    logic                          r_ovf;
    logic                          n_valid;
    logic [LINES-1:0][WORD_W-1:0]  n_word;
    logic                          n_ovf;
    logic [Q3_W-1:0]               rem1;
    logic [Q2_W-1:0]               rem2;
    logic [Q1_W-1:0]               rem3;
    logic [MAG_W-1:0]              rem4;
    logic [DIGITS-1:0][3:0]        dig;
    logic [LINES-1:0][SEG_W-1:0]   seg;
    t_pat                          pat;
    logic [WORD_W-1:0]             base3;

    assign o_ready = !r_valid || o_result.ready;

    // Digits from neighboring quotients: d = q_k - 10 * q_(k+1)
    assign rem1 = i_data.q3  - Q3_W'(i_data.q4) * Q3_W'(10);
    assign rem2 = i_data.q2  - Q2_W'(i_data.q3) * Q2_W'(10);
    assign rem3 = i_data.q1  - Q1_W'(i_data.q2) * Q1_W'(10);
    assign rem4 = i_data.mag - MAG_W'(i_data.q1) * MAG_W'(10);

    assign dig[0] = i_data.q4;
    assign dig[1] = rem1[3:0];
    assign dig[2] = rem2[3:0];
    assign dig[3] = rem3[3:0];
    assign dig[4] = rem4[3:0];

    // Place each digit at bits 2p+1..2p; drop a leading ten-thousands zero
    always_comb begin
        seg = '0;
        pat = '0;
        for (int p = 0; p < DIGITS; p++) begin
            pat = digit_pat(dig[p]);
            if (!(p == 0 && dig[p] == 4'd0)) begin
                for (int l = 0; l < LINES; l++) begin
                    seg[l][2*p +: 2] = pat[l];
                end
            end
        end
    end

    // Number-mode line 3 base: dot, optional minus and flag
    assign base3 = DOT_MARK
                 | (i_data.neg  ? MINUS_MARK : '0)
                 | (i_data.mark ? FLAG_MARK  : '0);

    // Select the words for the display kind
    always_comb begin
        n_word    = '0;
        n_ovf     = 1'b0;
        n_word[0] = UNIT_MARK | i_data.ind;
        case (t_kind'(i_data.kind))
            KIND_NUMBER: begin
                if (i_data.ovf) begin
                    n_word[0] = ERR_LINE0 | i_data.ind;
                    n_word[1] = ERR_LINE1;
                    n_word[2] = ERR_LINE2;
                    n_word[3] = base3 | ERR_LINE3;
                    n_ovf     = 1'b1;
                end else begin
                    n_word[0] = UNIT_MARK | i_data.ind | WORD_W'(seg[0]);
                    n_word[1] = WORD_W'(seg[1]);
                    n_word[2] = WORD_W'(seg[2]);
                    n_word[3] = base3 | WORD_W'(seg[3]);
                end
            end
            KIND_CONFIG: begin
                n_word[0] = CFG_LINE0 | i_data.ind;
                n_word[1] = CFG_LINE1;
                n_word[2] = CFG_LINE2;
                n_word[3] = CFG_LINE3;
            end
            KIND_DASHES: begin
                n_word[1] = DASH_ROW;
            end
            KIND_ALL_ON: begin
                n_word[0] = ALL_ON;
                n_word[1] = ALL_ON;
                n_word[2] = ALL_ON;
                n_word[3] = ALL_ON;
            end
            default: begin
                n_word[0] = UNIT_MARK | i_data.ind;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Load the result register when a new item arrives
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
            r_ovf  <= n_ovf;
        end
    end

    assign o_result.valid      = r_valid;
    assign o_result.line0_word = r_word[0];
    assign o_result.line1_word = r_word[1];
    assign o_result.line2_word = r_word[2];
    assign o_result.line3_word = r_word[3];
    assign o_result.overflow   = r_ovf;

endmodule

// File: rtl/core/signed_decimal_lcd_segment_encoder_top.sv
// ----------------------------------------------------------------------------
// signed_decimal_lcd_segment_encoder_top
// Converts display requests into four segment words for a 4-common LCD.
// ----------------------------------------------------------------------------
// Each accepted item gives exactly one result, which passes through the
// registers below and is held on the output until the output side takes it;
// a new item can be accepted every clock while the output side does not stall: the
// block is a three-register pipeline (input register, magnitude/quotient
// register, result register), each stage with its own valid bit so a stalled
// result does not stop earlier stages from filling. The quotient stage, with
// four parallel constant reciprocal multiplies, sets the clock period.
// Number mode shows a signed value as five decimal digits with a fixed point,
// unit mark and indicator mask; magnitudes of 100000 or more show the error
// pattern and raise overflow.
module signed_decimal_lcd_segment_encoder_top
    import sdlcd_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    sdlcd_item_if.sink     i_item,
    sdlcd_result_if.source o_result
);

`include "signed_decimal_lcd_segment_encoder_top_assert.svh"

    logic   cap_valid;
    logic   split_ready;
    t_item  cap_data;
    logic   split_valid;
    logic   enc_ready;
    t_split split_data;

    sdlcd_capture u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_valid (cap_valid),
        .i_ready (split_ready),
        .o_data  (cap_data)
    );

    sdlcd_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cap_valid),
        .o_ready (split_ready),
        .i_data  (cap_data),
        .o_valid (split_valid),
        .i_ready (enc_ready),
        .o_data  (split_data)
    );

    sdlcd_encode u_encode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (split_valid),
        .o_ready  (enc_ready),
        .i_data   (split_data),
        .o_result (o_result)
    );

    // Error pattern always carries the dash row on line 1
    `SDLCD_ASSERT_NOW(a_ovf_dash_row, i_clk, i_rst_n, o_result.valid && o_result.overflow, o_result.line1_word == ERR_LINE1)
    // Input is refused only while the input register holds an item
    `SDLCD_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !i_item.ready, cap_valid)
    // A stalled middle stage keeps its item
    `SDLCD_ASSERT_NEXT(a_split_holds, i_clk, i_rst_n, split_valid && !enc_ready, split_valid)

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the signed decimal LCD segment encoder against a local predictor.
// Drives display requests over the item channel, predicts the four segment
// words and the overflow flag for each accepted item, and compares every
// returned result in order. Covers number mode from blank zero to the error
// pattern, every fixed pattern and the unused kinds, random idling on both
// sides, a long output hold and a stretch at full rate.
// ----------------------------------------------------------------------------
module tb_top;
    import sdlcd_pkg::*;

    // Segment patterns as the glass is wired
    localparam logic [WORD_W-1:0] LCD_UNIT   = 12'h400;
    localparam logic [WORD_W-1:0] LCD_DOT    = 12'h008;
    localparam logic [WORD_W-1:0] LCD_MINUS  = 12'h002;
    localparam logic [WORD_W-1:0] LCD_FLAG   = 12'h800;
    localparam logic [WORD_W-1:0] LCD_DASHES = 12'h155;
    localparam logic [WORD_W-1:0] LCD_FULL   = 12'hFFF;
    // Rows listed line3 .. line0
    localparam logic [3:0][WORD_W-1:0] ERROR_ROWS  = {12'h041, 12'h1D5, 12'h155, 12'h403};
    localparam logic [3:0][WORD_W-1:0] CONFIG_ROWS = {12'h011, 12'h035, 12'h004, 12'h43F};
    // Per digit, two bits per common line, packed line3 .. line0
    localparam logic [9:0][7:0] DIGIT_SEGS = {
        8'b01_10_11_11,  // 9
        8'b01_11_11_11,  // 8
        8'b00_10_10_10,  // 7
        8'b01_11_01_11,  // 6
        8'b01_10_01_11,  // 5
        8'b00_10_11_01,  // 4
        8'b01_10_11_10,  // 3
        8'b01_01_11_10,  // 2
        8'b00_10_10_00,  // 1
        8'b01_11_10_11   // 0
    };
    localparam int DISPLAY_LIMIT = 100000;

    // Kinds past the defined set, shown blank
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 10;
    localparam int REPORT_CAP = 20;

    typedef struct packed {
        logic [3:0][WORD_W-1:0] line;
        logic                   overflow;
    } t_seg_words;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sdlcd_item_if   item_bus ();
    sdlcd_result_if result_bus ();

    signed_decimal_lcd_segment_encoder_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    always #5 i_clk = ~i_clk;

    t_seg_words expected_segments[$];
    int src_idle_pct = 30;
    int sink_idle_pct = 30;
    int hold_req = 0;
    int items_sent = 0;
    int number_items = 0;
    int overflow_items = 0;
    int results_checked = 0;
    int mismatches = 0;
    int stalled_cycles = 0;
    int full_rate_items = 0;

    // Predict the segment words for one display request
    function automatic t_seg_words encode_display(input logic [KIND_W-1:0] kind,
                                                  input logic [NUM_W-1:0] number,
                                                  input logic mark,
                                                  input logic [WORD_W-1:0] ind);
        t_seg_words r;
        int value;
        int mag;
        int place;
        int digit;
        r = '0;
        case (kind)
            KIND_NUMBER: begin
                r.line[0] = LCD_UNIT | ind;
                r.line[3] = LCD_DOT;
                value = $signed(number);
                if (value < 0) begin
                    r.line[3] |= LCD_MINUS;
                    mag = -value;
                end else begin
                    mag = value;
                end
                if (mark)
                    r.line[3] |= LCD_FLAG;
                if (mag >= DISPLAY_LIMIT) begin
                    // Too wide for five digits: error pattern over the base words
                    for (int k = 0; k < LINES; k++)
                        r.line[k] |= ERROR_ROWS[k];
                    r.overflow = 1'b1;
                end else begin
                    place = 10000;
                    for (int p = 0; p < DIGITS; p++) begin
                        digit = (mag / place) % 10;
                        place = place / 10;
                        // Blank only a leading ten-thousands zero
                        if (p != 0 || digit != 0) begin
                            for (int k = 0; k < LINES; k++)
                                r.line[k] |= {10'd0, DIGIT_SEGS[digit][2*k +: 2]} << (2 * p);
                        end
                    end
                end
            end
            KIND_CONFIG: begin
                r.line = CONFIG_ROWS;
                r.line[0] |= ind;
            end
            KIND_DASHES: begin
                r.line[0] = LCD_UNIT | ind;
                r.line[1] = LCD_DASHES;
            end
            KIND_ALL_ON: r.line = {LINES{LCD_FULL}};
            default: r.line[0] = LCD_UNIT | ind;
        endcase
        return r;
    endfunction

    // Pick a number that lands in every digit count, near the limit, or anywhere
    function automatic logic [NUM_W-1:0] random_number();
        int mag;
        int top;
        logic [NUM_W-1:0] n;
        case ($urandom_range(0, 9))
            0: return NUM_W'($urandom);
            1: mag = $urandom_range(99990, 100010);
            2: mag = $urandom_range(0, 99);
            default: begin
                top = 10 ** $urandom_range(1, 5);
                mag = $urandom_range(0, top - 1);
            end
        endcase
        n = mag[NUM_W-1:0];
        if ($urandom_range(0, 1))
            n = -n;
        return n;
    endfunction

    // Offer one item, with random idle cycles first, and hold it until taken
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [NUM_W-1:0] number,
                             input logic mark, input logic [WORD_W-1:0] ind);
        t_seg_words want;
        want = encode_display(kind, number, mark, ind);
        while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
            item_bus.valid          <= 1'b0;
            item_bus.kind           <= KIND_W'($urandom_range(0, 7));
            item_bus.number         <= NUM_W'($urandom);
            item_bus.extra_mark     <= 1'($urandom_range(0, 1));
            item_bus.indicator_bits <= WORD_W'($urandom);
            @(posedge i_clk);
        end
        item_bus.valid          <= 1'b1;
        item_bus.kind           <= kind;
        item_bus.number         <= number;
        item_bus.extra_mark     <= mark;
        item_bus.indicator_bits <= ind;
        @(posedge i_clk);
        while (!item_bus.ready)
            @(posedge i_clk);
        expected_segments.push_back(want);
        items_sent++;
        if (kind == KIND_NUMBER)
            number_items++;
        if (want.overflow)
            overflow_items++;
    endtask

    task automatic send_random_item();
        logic [KIND_W-1:0] kind;
        logic [NUM_W-1:0] number;
        if ($urandom_range(0, 99) < 65) begin
            kind = KIND_NUMBER;
            number = random_number();
        end else begin
            kind = KIND_W'($urandom_range(1, 7));
            number = NUM_W'($urandom);
        end
        send_item(kind, number, 1'($urandom_range(0, 1)), WORD_W'($urandom_range(0, 4095)));
    endtask

    // Extremes of every field, every kind, blanking and the error pattern
    task automatic test_directed();
        send_item(KIND_NUMBER, NUM_W'(0), 1'b0, 12'h000);
        send_item(KIND_NUMBER, NUM_W'(1), 1'b1, 12'hFFF);
        send_item(KIND_NUMBER, NUM_W'(-1), 1'b0, 12'h000);
        send_item(KIND_NUMBER, NUM_W'(9999), 1'b0, 12'hA5A);
        send_item(KIND_NUMBER, NUM_W'(10000), 1'b1, 12'h000);
        send_item(KIND_NUMBER, NUM_W'(-10000), 1'b0, 12'h5A5);
        send_item(KIND_NUMBER, NUM_W'(99999), 1'b0, 12'hFFF);
        send_item(KIND_NUMBER, NUM_W'(-99999), 1'b1, 12'h000);
        send_item(KIND_NUMBER, NUM_W'(12345), 1'b0, 12'h001);
        send_item(KIND_NUMBER, NUM_W'(-67890), 1'b1, 12'h800);
        send_item(KIND_NUMBER, NUM_W'(40506), 1'b0, 12'h000);
        send_item(KIND_NUMBER, NUM_W'(100000), 1'b0, 12'h000);
        send_item(KIND_NUMBER, NUM_W'(-100000), 1'b1, 12'hFFF);
        send_item(KIND_NUMBER, NUM_W'(524287), 1'b1, 12'hFFF);
        send_item(KIND_NUMBER, NUM_W'(-524288), 1'b0, 12'h000);
        send_item(KIND_CONFIG, NUM_W'(-524288), 1'b1, 12'hFFF);
        send_item(KIND_CONFIG, NUM_W'(0), 1'b0, 12'h000);
        send_item(KIND_DASHES, NUM_W'(12345), 1'b1, 12'h000);
        send_item(KIND_DASHES, NUM_W'(0), 1'b0, 12'hFFF);
        send_item(KIND_BLANK, NUM_W'(99999), 1'b1, 12'h3C3);
        send_item(KIND_ALL_ON, NUM_W'(0), 1'b0, 12'h123);
        send_item(KIND_ALL_ON, NUM_W'(-1), 1'b1, 12'h000);
        for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
            send_item(KIND_W'(k), NUM_W'(777), 1'b1, 12'h0F0);
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++)
            send_random_item();
    endtask

    // Stall the output long enough that the pipeline fills and refuses input
    task automatic test_backpressure(input int count);
        src_idle_pct = 0;
        hold_req++;
        for (int i = 0; i < count; i++)
            send_random_item();
        src_idle_pct = 30;
    endtask

    // One item per cycle with neither side idling
    task automatic test_full_rate(input int count);
        src_idle_pct = 0;
        sink_idle_pct = 0;
        for (int i = 0; i < count; i++)
            send_random_item();
        full_rate_items += count;
        src_idle_pct = 30;
        sink_idle_pct = 30;
    endtask

    // Output side: random ready, plus a long hold on request
    initial begin : drive_ready
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                result_bus.ready <= 1'b0;
                hold_left--;
            end else begin
                result_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // Compare each returned item with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_seg_words want;
        logic [3:0][WORD_W-1:0] got;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            results_checked++;
            got = {result_bus.line3_word, result_bus.line2_word,
                   result_bus.line1_word, result_bus.line0_word};
            if (expected_segments.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: result with nothing pending, expected none actual %h %h",
                             $time, got, result_bus.overflow);
            end else begin
                want = expected_segments.pop_front();
                for (int k = 0; k < LINES; k++) begin
                    if (got[k] !== want.line[k]) begin
                        mismatches++;
                        if (mismatches <= REPORT_CAP)
                            $display("%0t: line%0d_word expected %h actual %h",
                                     $time, k, want.line[k], got[k]);
                    end
                end
                if (result_bus.overflow !== want.overflow) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t: overflow expected %b actual %b",
                                 $time, want.overflow, result_bus.overflow);
                end
            end
        end
    end

    // End the run if nothing moves on either side for too long
    always @(posedge i_clk) begin
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
            if (stalled_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, no item moved for %0d cycles, %0d still pending",
                         $time, stalled_cycles, expected_segments.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n                 <= 1'b0;
        item_bus.valid          <= 1'b0;
        item_bus.kind           <= '0;
        item_bus.number         <= '0;
        item_bus.extra_mark     <= 1'b0;
        item_bus.indicator_bits <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_mix(900);
        test_backpressure(60);
        test_full_rate(300);
        test_random_mix(550);

        // Drain: wait for every prediction to be matched, then idle before the report
        item_bus.valid <= 1'b0;
        while (expected_segments.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items (%0d in number mode, %0d past five digits), checked %0d results",
                 items_sent, number_items, overflow_items, results_checked);
        $display("Run included a %0d-cycle output hold and %0d items at full rate",
                 HOLD_CYCLES, full_rate_items);
        if (mismatches == 0 && expected_segments.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/sdlcd_pkg.sv
rtl/core/sdlcd_item_if.sv
rtl/core/sdlcd_result_if.sv
rtl/core/sdlcd_capture.sv
rtl/core/sdlcd_split.sv
rtl/core/sdlcd_encode.sv
rtl/core/signed_decimal_lcd_segment_encoder_top.sv
dv/tb_top.sv
